FILE: hdl/chacha20_stream_cipher_defines.svh
// Assertion macros for the ChaCha20 stream cipher block.
`ifndef CHACHA20_STREAM_CIPHER_DEFINES_SVH
`define CHACHA20_STREAM_CIPHER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define CHACHA_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("chacha assertion failed");

// Next-cycle implication, disabled during reset.
`define CHACHA_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("chacha assertion failed");

`endif

FILE: hdl/chacha_pkg.sv
// Package with types, constants and helper functions for the ChaCha20 stream cipher.
`timescale 1ns / 1ps

package chacha_pkg;

  localparam int DOUBLE_ROUNDS_DEF = 10;
  localparam int WORD_W            = 32;
  localparam int TEXT_W            = 64;
  localparam int CFG_IDX_W         = 3;
  localparam int CFG_DATA_W        = 64;

  localparam logic [WORD_W-1:0] SIGMA_0 = 32'h6170_7865;
  localparam logic [WORD_W-1:0] SIGMA_1 = 32'h3320_646e;
  localparam logic [WORD_W-1:0] SIGMA_2 = 32'h7962_2d32;
  localparam logic [WORD_W-1:0] SIGMA_3 = 32'h6b20_6574;

  localparam logic [CFG_IDX_W-1:0] CFG_KEY_01     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_23     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_45     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_67     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_NONCE_LOW  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_NONCE_HIGH = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_CTR   = 3'd6;

  localparam logic [2:0] LAST_WORD_POS = 3'd7;
  localparam logic [1:0] LAST_STEP     = 2'd3;

  typedef struct packed {
    logic [TEXT_W-1:0] text_word;
    logic              message_start;
  } text_item_t;

  typedef struct packed {
    logic [TEXT_W-1:0] cipher_word;
    logic              block_end;
  } cipher_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROUND,
    ST_FINAL,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic text_stall;
    logic load_en;
    logic arx_en;
    logic fin_en;
    logic emit_en;
  } ctrl_t;

  // Rotate left by 16, 12, 8 or 7 for quarter-round steps 0 to 3.
  function automatic logic [WORD_W-1:0] arx_rotl(input logic [WORD_W-1:0] v,
                                                 input logic [1:0] step);
    logic [WORD_W-1:0] r;
    case (step)
      2'd0:    r = {v[15:0], v[31:16]};
      2'd1:    r = {v[19:0], v[31:20]};
      2'd2:    r = {v[23:0], v[31:24]};
      default: r = {v[24:0], v[31:25]};
    endcase
    return r;
  endfunction

endpackage

FILE: hdl/chacha20_stream_cipher.sv
// ChaCha20 stream cipher: 64-bit words in, 64-bit ciphertext words out.
// Usage:
//   Text channel: text (text_word, message_start) with text_valid/text_stall.
//   Cipher channel: cipher (cipher_word, block_end) with cipher_valid/cipher_stall.
//   Configuration: cfg_write, cfg_index, cfg_data; key, nonce and start counter.
// Timing:
//   A word at block position zero, or one with message_start, runs a keystream
//   block through one shared four-lane add/xor/rotate unit: 4 steps per round,
//   2*DOUBLE_ROUNDS rounds, then the feed-forward add. The result is then
//   registered in the output register; the block can take its next word
//   in the cycle after the result is registered.
//   Other words are enciphered from the held block; the block takes no new
//   word until that result is in the output register.
// Reset clears configuration, block counter and word position.
// A stalled result stays in the output register; the block may accept one
// more word meanwhile and then holds text_stall until the result is taken.
`timescale 1ns / 1ps
`include "chacha20_stream_cipher_defines.svh"

module chacha20_stream_cipher #(
  parameter int DOUBLE_ROUNDS = chacha_pkg::DOUBLE_ROUNDS_DEF
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     text_valid,
  output logic                                     text_stall,
  input  chacha_pkg::text_item_t                   text,
  output logic                                     cipher_valid,
  input  logic                                     cipher_stall,
  output chacha_pkg::cipher_item_t                 cipher,
  input  logic                                     cfg_write,
  input  logic [chacha_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [chacha_pkg::CFG_DATA_W-1:0]        cfg_data
);
  import chacha_pkg::*;

  localparam int NUM_ROUNDS = 2 * DOUBLE_ROUNDS;
  localparam int RND_W      = $clog2(NUM_ROUNDS);
  localparam logic [RND_W-1:0] LAST_ROUND = RND_W'(NUM_ROUNDS - 1);

  logic [63:0] key_01, key_23, key_45, key_67, nonce_low;
  logic [31:0] nonce_high, initial_counter;

  state_t state, state_next;
  ctrl_t  ctrl;

  logic [2:0]        word_position;
  logic [31:0]       block_counter;
  logic [RND_W-1:0]  rnd;
  logic [1:0]        step;
  logic [63:0]       text_hold;

  logic [31:0] round_state [16];
  logic [31:0] arx_state   [16];
  logic [31:0] init_state  [16];
  logic [31:0] init_ctr;
  logic [63:0] keystream;
  logic        text_accept;
  logic        out_free;
  logic        diag;

  assign text_accept = text_valid && !text_stall;
  assign out_free    = !cipher_valid || !cipher_stall;
  assign diag        = rnd[0];
  assign text_stall  = ctrl.text_stall;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      key_01          <= '0;
      key_23          <= '0;
      key_45          <= '0;
      key_67          <= '0;
      nonce_low       <= '0;
      nonce_high      <= '0;
      initial_counter <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_KEY_01:     key_01          <= cfg_data;
        CFG_KEY_23:     key_23          <= cfg_data;
        CFG_KEY_45:     key_45          <= cfg_data;
        CFG_KEY_67:     key_67          <= cfg_data;
        CFG_NONCE_LOW:  nonce_low       <= cfg_data;
        CFG_NONCE_HIGH: nonce_high      <= cfg_data[31:0];
        CFG_INIT_CTR:   initial_counter <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (text_accept) begin
          if (text.message_start || word_position == '0) begin
            state_next = ST_ROUND;
          end else begin
            state_next = ST_EMIT;
          end
        end
      end
      ST_ROUND: begin
        if (step == LAST_STEP && rnd == LAST_ROUND) begin
          state_next = ST_FINAL;
        end
      end
      ST_FINAL: state_next = ST_EMIT;
      ST_EMIT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // control outputs; text is never stalled in ST_IDLE
  always_comb begin
    ctrl = '0;
    case (state)
      ST_IDLE: begin
        ctrl.load_en = text_valid && (text.message_start || word_position == '0);
      end
      ST_ROUND: begin
        ctrl.text_stall = 1'b1;
        ctrl.arx_en     = 1'b1;
      end
      ST_FINAL: begin
        ctrl.text_stall = 1'b1;
        ctrl.fin_en     = 1'b1;
      end
      ST_EMIT: begin
        ctrl.text_stall = 1'b1;
        ctrl.emit_en    = out_free;
      end
      default: ctrl.text_stall = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // input state words: constants, key, counter, nonce
  assign init_ctr = (state == ST_IDLE && text.message_start) ? initial_counter : block_counter;

  always_comb begin
    init_state[0]  = SIGMA_0;
    init_state[1]  = SIGMA_1;
    init_state[2]  = SIGMA_2;
    init_state[3]  = SIGMA_3;
    init_state[4]  = key_01[31:0];
    init_state[5]  = key_01[63:32];
    init_state[6]  = key_23[31:0];
    init_state[7]  = key_23[63:32];
    init_state[8]  = key_45[31:0];
    init_state[9]  = key_45[63:32];
    init_state[10] = key_67[31:0];
    init_state[11] = key_67[63:32];
    init_state[12] = init_ctr;
    init_state[13] = nonce_low[31:0];
    init_state[14] = nonce_low[63:32];
    init_state[15] = nonce_high;
  end

  // shared unit: one add/xor/rotate step on four quarter-round lanes
  always_comb begin
    int ia, ib, ic, id;
    logic [31:0] x, y, z, sm;
    arx_state = round_state;
    for (int i = 0; i < 4; i++) begin
      ia = i;
      if (diag) begin
        ib = 4 + ((i + 1) % 4);
        ic = 8 + ((i + 2) % 4);
        id = 12 + ((i + 3) % 4);
      end else begin
        ib = 4 + i;
        ic = 8 + i;
        id = 12 + i;
      end
      if (step[0]) begin
        x = round_state[ic];
        y = round_state[id];
        z = round_state[ib];
      end else begin
        x = round_state[ia];
        y = round_state[ib];
        z = round_state[id];
      end
      sm = x + y;
      if (step[0]) begin
        arx_state[ic] = sm;
        arx_state[ib] = arx_rotl(z ^ sm, step);
      end else begin
        arx_state[ia] = sm;
        arx_state[id] = arx_rotl(z ^ sm, step);
      end
    end
  end

  // working state; holds the keystream block after the feed-forward add
  always_ff @(posedge clk) begin
    for (int i = 0; i < 16; i++) begin
      if (ctrl.load_en) begin
        round_state[i] <= init_state[i];
      end else if (ctrl.arx_en) begin
        round_state[i] <= arx_state[i];
      end else if (ctrl.fin_en) begin
        round_state[i] <= round_state[i] + init_state[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rnd  <= '0;
      step <= '0;
    end else if (ctrl.load_en) begin
      rnd  <= '0;
      step <= '0;
    end else if (ctrl.arx_en) begin
      step <= step + 2'd1;
      if (step == LAST_STEP) begin
        rnd <= rnd + RND_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (text_accept) begin
      text_hold <= text.text_word;
    end
  end

  assign keystream = {round_state[{word_position, 1'b1}], round_state[{word_position, 1'b0}]};

  always_ff @(posedge clk) begin
    if (rst) begin
      word_position <= '0;
      block_counter <= '0;
    end else if (text_accept && text.message_start) begin
      word_position <= '0;
      block_counter <= initial_counter;
    end else if (ctrl.emit_en) begin
      word_position <= word_position + 3'd1;
      if (word_position == LAST_WORD_POS) begin
        block_counter <= block_counter + 32'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cipher_valid <= 1'b0;
    end else if (ctrl.emit_en) begin
      cipher_valid <= 1'b1;
    end else if (!cipher_stall) begin
      cipher_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.emit_en) begin
      cipher.cipher_word <= text_hold ^ keystream;
      cipher.block_end   <= (word_position == LAST_WORD_POS);
    end
  end

  `CHACHA_ASSERT_NEXT(a_mid_block_skips_rounds, clk, rst,
    state == ST_IDLE && text_accept && !text.message_start && word_position != '0,
    state == ST_EMIT)
  `CHACHA_ASSERT_NEXT(a_final_then_emit, clk, rst, state == ST_FINAL, state == ST_EMIT)
  `CHACHA_ASSERT_NEXT(a_emit_delivers, clk, rst, state == ST_EMIT && out_free,
    cipher_valid && state == ST_IDLE)
  `CHACHA_ASSERT_NEXT(a_counter_steps_at_block_end, clk, rst,
    ctrl.emit_en && word_position == LAST_WORD_POS,
    word_position == '0 && block_counter == $past(block_counter) + 32'd1)

endmodule

FILE: test/tb_chacha20_stream_cipher.sv
// Self-checking testbench for the ChaCha20 stream cipher block.
`timescale 1ns / 1ps

module tb_chacha20_stream_cipher;
  import chacha_pkg::*;

  localparam int CLK_PERIOD     = 4;
  localparam int RESET_CYCLES   = 10;
  localparam int ROUND_PAIRS    = DOUBLE_ROUNDS_DEF;
  localparam int SETTLE_CYCLES  = 100;
  localparam int HOLD_CYCLES    = 500;
  localparam int HOLD_AFTER     = 400;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int RAND_PHASES    = 7;
  localparam int PHASE_ITEMS    = 175;
  localparam int REPORT_LIMIT   = 10;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

  // Keystream predictor and store of expected cipher transactions.
  class cipher_scoreboard;
    bit [63:0]    key_pair [4];
    bit [63:0]    nonce_lo;
    bit [31:0]    nonce_hi;
    bit [31:0]    start_count;
    bit [63:0]    keystream [8];
    bit [31:0]    work [16];
    bit [2:0]     word_pos;
    bit [31:0]    block_count;
    cipher_item_t expected_q [$];
    int           failures;

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_KEY_01:     key_pair[0] = data;
        CFG_KEY_23:     key_pair[1] = data;
        CFG_KEY_45:     key_pair[2] = data;
        CFG_KEY_67:     key_pair[3] = data;
        CFG_NONCE_LOW:  nonce_lo = data;
        CFG_NONCE_HIGH: nonce_hi = data[31:0];
        CFG_INIT_CTR:   start_count = data[31:0];
        default: ;
      endcase
    endfunction

    function bit [31:0] rotl(bit [31:0] v, int n);
      return (v << n) | (v >> (32 - n));
    endfunction

    function void quarter(int a, int b, int c, int d);
      work[a] += work[b]; work[d] = rotl(work[d] ^ work[a], 16);
      work[c] += work[d]; work[b] = rotl(work[b] ^ work[c], 12);
      work[a] += work[b]; work[d] = rotl(work[d] ^ work[a], 8);
      work[c] += work[d]; work[b] = rotl(work[b] ^ work[c], 7);
    endfunction

    function void make_keystream();
      bit [31:0] init [16];
      init[0] = SIGMA_0;
      init[1] = SIGMA_1;
      init[2] = SIGMA_2;
      init[3] = SIGMA_3;
      for (int i = 0; i < 4; i++) begin
        init[4 + 2 * i] = key_pair[i][31:0];
        init[5 + 2 * i] = key_pair[i][63:32];
      end
      init[12] = block_count;
      init[13] = nonce_lo[31:0];
      init[14] = nonce_lo[63:32];
      init[15] = nonce_hi;
      work = init;
      for (int r = 0; r < ROUND_PAIRS; r++) begin
        quarter(0, 4, 8, 12);
        quarter(1, 5, 9, 13);
        quarter(2, 6, 10, 14);
        quarter(3, 7, 11, 15);
        quarter(0, 5, 10, 15);
        quarter(1, 6, 11, 12);
        quarter(2, 7, 8, 13);
        quarter(3, 4, 9, 14);
      end
      for (int i = 0; i < 16; i++) work[i] += init[i];
      for (int i = 0; i < 8; i++) keystream[i] = {work[2 * i + 1], work[2 * i]};
    endfunction

    function void note_text(text_item_t t);
      cipher_item_t exp;
      if (t.message_start) begin
        block_count = start_count;
        word_pos = '0;
      end
      if (word_pos == '0) make_keystream();
      exp.cipher_word = t.text_word ^ keystream[word_pos];
      exp.block_end   = (word_pos == LAST_WORD_POS);
      expected_q.push_back(exp);
      if (word_pos == LAST_WORD_POS) block_count++;
      word_pos++;
    endfunction

    function void check_cipher(cipher_item_t got);
      cipher_item_t exp;
      if (expected_q.size() == 0) begin
        failures++;
        if (failures <= REPORT_LIMIT)
          $display("unexpected cipher transaction: %h block_end %b",
                   got.cipher_word, got.block_end);
        return;
      end
      exp = expected_q.pop_front();
      if (got.cipher_word !== exp.cipher_word || got.block_end !== exp.block_end) begin
        failures++;
        if (failures <= REPORT_LIMIT)
          $display("cipher mismatch: expected %h block_end %b, got %h block_end %b",
                   exp.cipher_word, exp.block_end, got.cipher_word, got.block_end);
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  text_valid;
  logic                  text_stall;
  text_item_t            text;
  logic                  cipher_valid;
  logic                  cipher_stall;
  cipher_item_t          cipher;
  logic                  cfg_write;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  cipher_scoreboard board;
  bit               steady;
  int               results_seen;
  int unsigned      quiet_cycles;

  chacha20_stream_cipher #(
    .DOUBLE_ROUNDS(DOUBLE_ROUNDS_DEF)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .text_valid   (text_valid),
    .text_stall   (text_stall),
    .text         (text),
    .cipher_valid (cipher_valid),
    .cipher_stall (cipher_stall),
    .cipher       (cipher),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [63:0] pick_value();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic send_text(input logic [63:0] word, input logic start);
    text_item_t item;
    int         gap;
    item.text_word     = word;
    item.message_start = start;
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      text_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    text_valid <= 1'b1;
    text       <= item;
    @(posedge clk);
    while (text_stall !== 1'b0) @(posedge clk);
    board.note_text(item);
  endtask

  task automatic send_message(input int words, input bit well_formed);
    logic start;
    for (int i = 0; i < words; i++) begin
      if (well_formed) start = (i == 0);
      else start = ($urandom_range(0, 3) == 0);
      send_text(($urandom_range(0, 9) == 0) ? pick_value() : {$urandom, $urandom}, start);
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    board.write_reg(idx, data);
  endtask

  // Drain all outstanding transactions so the block is idle.
  task automatic settle();
    text_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic configure(input int phase);
    logic [63:0] value;
    for (int i = CFG_KEY_01; i <= CFG_INIT_CTR; i++) begin
      if (phase == 0) value = '0;
      else if (phase == 1) value = '1;
      else if (i == CFG_INIT_CTR && $urandom_range(0, 3) == 0) value = {$urandom, 32'hFFFF_FFFE};
      else value = pick_value();
      write_reg(i[CFG_IDX_W-1:0], value);
    end
    if ($urandom_range(0, 1) == 1) write_reg(CFG_UNUSED, {$urandom, $urandom});
    cfg_write <= 1'b0;
  endtask

  always @(posedge clk) begin
    if (!rst && cipher_valid && !cipher_stall) begin
      board.check_cipher(cipher);
      results_seen <= results_seen + 1;
    end
  end

  always @(posedge clk) begin
    if (rst || (text_valid && !text_stall) || (cipher_valid && !cipher_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off so the block backs up.
  initial begin
    bit held_off;
    int n;
    held_off = 1'b0;
    cipher_stall = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (!held_off && results_seen >= HOLD_AFTER) begin
        held_off = 1'b1;
        cipher_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        n = pick_gap();
        if (n > 0) begin
          cipher_stall <= 1'b1;
          repeat (n) @(posedge clk);
        end
        cipher_stall <= 1'b0;
        n = ($urandom_range(0, 19) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 4);
        repeat (n) @(posedge clk);
      end
    end
  end

  initial begin
    int sent;
    int len;
    rst          = 1'b1;
    text_valid   = 1'b0;
    text         = '0;
    cfg_write    = 1'b0;
    cfg_index    = CFG_KEY_01;
    cfg_data     = '0;
    steady       = 1'b0;
    board = new();
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // No message start after reset: counter runs from zero on the reset key.
    send_text(64'h0, 1'b0);
    send_text('1, 1'b0);
    send_text(64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
    settle();
    // Mid-block write: the new key only takes effect at the next block.
    write_reg(CFG_KEY_01, '1);
    write_reg(CFG_KEY_23, '1);
    write_reg(CFG_KEY_45, '1);
    write_reg(CFG_KEY_67, '1);
    write_reg(CFG_NONCE_LOW, '1);
    write_reg(CFG_NONCE_HIGH, '1);
    write_reg(CFG_INIT_CTR, '1);
    write_reg(CFG_UNUSED, 64'h0123_4567_89AB_CDEF);
    cfg_write <= 1'b0;
    send_text(64'h5555_5555_5555_5555, 1'b0);
    send_text(64'h0123_4567_89AB_CDEF, 1'b0);
    for (int i = 0; i < 4; i++) send_text({$urandom, $urandom}, 1'b0);
    // Counter wrap across two blocks.
    for (int i = 0; i < 16; i++) send_text({$urandom, $urandom}, i == 0);

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      settle();
      configure(ph);
      steady = (ph % 3 == 2);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        if ($urandom_range(0, 9) < 8) begin
          len = ($urandom_range(0, 9) < 7) ? 8 * $urandom_range(1, 3) : $urandom_range(1, 30);
          send_message(len, 1'b1);
        end else begin
          len = $urandom_range(1, 12);
          send_message(len, 1'b0);
        end
        sent += len;
      end
    end
    steady = 1'b0;
    settle();

    if (board.failures == 0 && board.pending() == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

FILE: files.f
+incdir+hdl
hdl/chacha_pkg.sv
hdl/chacha20_stream_cipher.sv
test/tb_chacha20_stream_cipher.sv
